// File: sv/gwtp_pkg.sv
package gwtp_pkg;

    // Field widths fixed by the interface.
    localparam int VTX_W  = 8;
    localparam int EID_W  = 10;
    localparam int GEN_W  = 8;

    // Tag memory depths (powers of two; ids index them modulo the depth).
    localparam int VERTEX_COUNT = 256;
    localparam int EDGE_COUNT   = 1024;
    localparam int VTX_AW       = $clog2(VERTEX_COUNT);
    localparam int EDGE_AW      = $clog2(EDGE_COUNT);

    // The clearing sweep covers the deeper of the two memories.
    localparam int CLR_AW = (VTX_AW > EDGE_AW) ? VTX_AW : EDGE_AW;

    typedef logic [VTX_W-1:0]   t_vtx;
    typedef logic [EID_W-1:0]   t_eid;
    typedef logic [GEN_W-1:0]   t_gen;
    typedef logic [VTX_AW-1:0]  t_vtx_addr;
    typedef logic [EDGE_AW-1:0] t_edge_addr;
    typedef logic [CLR_AW-1:0]  t_clr_addr;

    localparam t_gen      GEN_NONE = '0;
    localparam t_gen      GEN_MAX  = '1;
    localparam t_clr_addr CLR_LAST = '1;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // Control from the clearing sequencer to the datapath.
    typedef struct packed {
        logic      busy;
        logic      done;
        t_clr_addr addr;
    } t_clr_ctl;

endpackage

// File: sv/gwtp_seen_ram.sv
module gwtp_seen_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Read-first: a read and a write of the same entry in one cycle return the old tag.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gwtp_sweep.sv
module gwtp_sweep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wrap_req,
    output gwtp_pkg::t_clr_ctl o_clr
);

    import gwtp_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_clr_addr r_cnt;
    t_clr_addr n_cnt;
    logic      w_busy;
    logic      w_last;

    assign w_last = (r_cnt == CLR_LAST);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_wrap_req) begin
                    n_state = ST_CLEAR;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: w_busy = 1'b1;
            ST_RUN:   w_busy = 1'b0;
            default:  w_busy = 1'b1;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_busy) begin
            n_cnt = w_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_clr.busy = w_busy;
    assign o_clr.done = w_busy & w_last;
    assign o_clr.addr = r_cnt;

endmodule

// File: sv/graph_walk_trail_path_checker_core.sv
// Channel   Direction  Handshake            Word
// input     in         i_valid / o_ready    first_edge, last_edge, start_vertex, end_a,
//                                           end_b, edge_id
// result    out        o_valid / i_ready    walk_valid, edges_unique, is_path, end_vertex,
//                                           walk_done
//
// One word is accepted per cycle while no sweep, pending wrap or stalled result holds the input;
// each gives one result word, which passes through the registered tag memory reads and then
// the output register. After reset a clearing sweep writes zero through both tag memories,
// one entry a cycle, over all 1024 addresses of the edge tag memory; no word is accepted during it.
// The same sweep runs when a word starting a new walk arrives while the generation
// counter stands at its maximum; that word waits and is accepted once the sweep ends.
// A stalled result holds the second stage, and the input is then refused as well.
module graph_walk_trail_path_checker_core (
    input  logic           i_clk,
    input  logic           i_rst_n,

    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_first_edge,
    input  logic           i_last_edge,
    input  gwtp_pkg::t_vtx i_start_vertex,
    input  gwtp_pkg::t_vtx i_end_a,
    input  gwtp_pkg::t_vtx i_end_b,
    input  gwtp_pkg::t_eid i_edge_id,

    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_walk_valid,
    output logic           o_edges_unique,
    output logic           o_is_path,
    output gwtp_pkg::t_vtx o_end_vertex,
    output logic           o_walk_done
);

    import gwtp_pkg::*;

    // Walk state kept in registers: the current vertex, the validity flag, the generation
    // and the start vertex of the walk. The start vertex is compared directly, so the
    // vertex memory needs only one write per word.
    t_vtx      r_cur;
    logic      r_valid;
    t_gen      r_gen;
    t_vtx_addr r_start;
    logic      r_trail;
    logic      r_path;

    // Clearing sequencer: runs after reset and when the generation counter would wrap.
    t_clr_ctl w_clr;
    logic     w_wrap_req;

    assign w_wrap_req = i_valid & i_first_edge & (r_gen == GEN_MAX) & ~w_clr.busy;

    gwtp_sweep u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wrap_req (w_wrap_req),
        .o_clr      (w_clr)
    );

    // Second stage, waiting for the tag read data.
    logic      r_s1_v;
    logic      r_s1_first;
    logic      r_s1_last;
    logic      r_s1_valid;
    logic      r_s1_start_hit;
    t_gen      r_s1_gen;
    t_vtx      r_s1_vertex;

    // Output register.
    logic      r_out_v;
    logic      r_out_walk_valid;
    logic      r_out_trail;
    logic      r_out_path;
    t_vtx      r_out_vertex;
    logic      r_out_done;

    logic      w_s1_adv;
    logic      w_accept;
    t_vtx      w_cur_eff;
    logic      w_a_hit;
    logic      w_touch;
    t_vtx      w_next;
    t_gen      w_gen_eff;
    t_vtx_addr w_start_eff;
    t_vtx_addr w_next_idx;
    logic      w_start_hit;
    logic      w_valid_new;

    t_gen       w_e_rdata;
    t_gen       w_v_rdata;
    logic       w_mem_we;
    t_edge_addr w_e_addr;
    t_vtx_addr  w_v_addr;
    t_gen       w_wdata;

    logic       w_e_hit;
    logic       w_v_hit;
    logic       w_trail_new;
    logic       w_path_new;

    assign w_s1_adv = r_s1_v & (~r_out_v | i_ready);
    assign o_ready  = ~w_clr.busy & ~(i_first_edge & (r_gen == GEN_MAX))
                    & (~r_s1_v | w_s1_adv);
    assign w_accept = i_valid & o_ready;

    // First stage: step the walk and issue the tag reads and writes.
    assign w_cur_eff   = i_first_edge ? i_start_vertex : r_cur;
    assign w_a_hit     = (i_end_a == w_cur_eff);
    assign w_touch     = w_a_hit | (i_end_b == w_cur_eff);
    assign w_next      = w_a_hit ? i_end_b : i_end_a;
    assign w_gen_eff   = i_first_edge ? r_gen + 1'b1 : r_gen;
    assign w_start_eff = i_first_edge ? i_start_vertex[VTX_AW-1:0] : r_start;
    assign w_next_idx  = w_next[VTX_AW-1:0];
    assign w_start_hit = (w_gen_eff != GEN_NONE) & (w_next_idx == w_start_eff);
    assign w_valid_new = (i_first_edge | r_valid) & w_touch;

    // Each tag memory is written with the word's generation in the cycle it is read, so
    // a later word always sees the earlier mark and no forwarding is needed.
    assign w_mem_we = w_accept | w_clr.busy;
    assign w_wdata  = w_clr.busy ? GEN_NONE : w_gen_eff;
    assign w_e_addr = w_clr.busy ? w_clr.addr[EDGE_AW-1:0] : i_edge_id[EDGE_AW-1:0];
    assign w_v_addr = w_clr.busy ? w_clr.addr[VTX_AW-1:0] : w_next_idx;

    gwtp_seen_ram #(
        .AW (EDGE_AW),
        .DW (GEN_W)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_accept),
        .i_addr  (w_e_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_e_rdata)
    );

    gwtp_seen_ram #(
        .AW (VTX_AW),
        .DW (GEN_W)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_accept),
        .i_addr  (w_v_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_v_rdata)
    );

    // Second stage: an entry counts as seen when its tag matches a live generation.
    assign w_e_hit     = (r_s1_gen != GEN_NONE) & (w_e_rdata == r_s1_gen);
    assign w_v_hit     = r_s1_start_hit | ((r_s1_gen != GEN_NONE) & (w_v_rdata == r_s1_gen));
    assign w_trail_new = (r_s1_first | r_trail) & ~w_e_hit;
    assign w_path_new  = (r_s1_first | r_path) & ~w_v_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_valid <= 1'b1;
            r_gen   <= GEN_NONE;
            r_start <= '0;
            r_trail <= 1'b1;
            r_path  <= 1'b1;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_clr.done) begin
                r_gen <= GEN_NONE;
            end else if (w_accept) begin
                r_gen <= w_gen_eff;
            end
            if (w_accept) begin
                r_cur   <= w_next;
                r_valid <= w_valid_new;
                r_start <= w_start_eff;
            end
            if (w_s1_adv) begin
                r_trail <= w_trail_new;
                r_path  <= w_path_new;
            end
            if (w_accept) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_first     <= i_first_edge;
            r_s1_last      <= i_last_edge;
            r_s1_valid     <= w_valid_new;
            r_s1_start_hit <= w_start_hit;
            r_s1_gen       <= w_gen_eff;
            r_s1_vertex    <= w_next;
        end
        if (w_s1_adv) begin
            r_out_walk_valid <= r_s1_valid;
            r_out_trail      <= w_trail_new;
            r_out_path       <= w_path_new;
            r_out_vertex     <= r_s1_vertex;
            r_out_done       <= r_s1_last;
        end
    end

    assign o_valid        = r_out_v;
    assign o_walk_valid   = r_out_walk_valid;
    assign o_edges_unique = r_out_trail;
    assign o_is_path      = r_out_path;
    assign o_end_vertex   = r_out_vertex;
    assign o_walk_done    = r_out_done;

    // No word may enter while the tag memories are being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_clr.busy)
        else $error("word accepted during tag clearing");

    // A finished sweep leaves the generation at zero, ready for the next walk.
    a_gen_zero_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr.done |=> (r_gen == GEN_NONE))
        else $error("generation not reset after sweep");

    // Starting a walk always yields a live generation.
    a_gen_live_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_first_edge) |=> (r_gen != GEN_NONE))
        else $error("new walk started with dead generation");

    // A stalled second stage keeps its word and the read data it depends on.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_s1_adv) |=> (r_s1_v && $stable(r_s1_gen) && $stable(w_e_rdata)
                                   && $stable(w_v_rdata)))
        else $error("second stage lost its word while stalled");

endmodule
